### sv/gss_pkg.sv
// Shared types and fixed widths of the Gini split scan block.
`default_nettype none
package gss_pkg;

	localparam int COORD_W = 16;
	localparam int COUNT_W = 20;
	localparam int FRAC_W = 16;
	localparam int SAMPLE_W = 21;

	// Proportions and volumes in Q0.F carry one extra bit to hold 1.0.
	localparam int PROP_W = FRAC_W + 1;
	localparam int EMPTY_W = SAMPLE_W + PROP_W;
	localparam int TOT_W = EMPTY_W + 1;
	localparam int SUM_W = TOT_W + 1;
	localparam int MUL_W = EMPTY_W + SAMPLE_W;
	localparam int NUM_W = MUL_W + FRAC_W;
	localparam int DIV_W = SUM_W;
	localparam int QUO_W = EMPTY_W;
	localparam int QB_W = $clog2(QUO_W + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = SAMPLE_W;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TOTAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_TOTAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_SIZE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEAST_SAMPLES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEAST_SIZE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LEAST_SHARE = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0] split_value;
		logic [SAMPLE_W-1:0] left_count;
		logic last;
	} item_t;

	typedef struct packed {
		logic [FRAC_W-1:0] top_gain;
		logic [COORD_W-1:0] top_split;
		logic found;
		logic [COUNT_W-1:0] sample_hits;
		logic [COUNT_W-1:0] size_hits;
		logic [COUNT_W-1:0] share_hits;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] node_low;
		logic [COORD_W-1:0] node_high;
		logic [SAMPLE_W-1:0] sample_total;
		logic [SAMPLE_W-1:0] empty_total;
		logic [PROP_W-1:0] node_size;
		logic [SAMPLE_W-1:0] least_samples;
		logic [PROP_W-1:0] least_size;
		logic [PROP_W-1:0] least_share;
	} cfg_t;

	typedef struct packed {
		logic go;
		logic [QB_W-1:0] qbits;
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage
`default_nettype wire

### sv/gss_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module gss_div (
	input logic clk,
	input logic arst_n,
	input gss_pkg::div_req_t req,
	output gss_pkg::div_rsp_t rsp
);
	import gss_pkg::*;

	logic [QB_W-1:0] cnt_q;
	logic done_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic qbit;
	logic [QB_W-1:0] align;

	// The quotient is known to fit in qbits, so the numerator bits above
	// that point already form a remainder smaller than the divisor.
	assign align = QB_W'(QUO_W) - req.qbits;
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign qbit = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				cnt_q <= req.qbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QB_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= DIV_W'(req.num >> req.qbits);
			low_q <= QUO_W'(req.num << align);
			den_q <= req.den;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule
`default_nettype wire

### sv/gss_cfg.sv
// Configuration register file of the Gini split scan block.
`default_nettype none
module gss_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gss_pkg::CFG_DATA_W-1:0] cfg_data,
	output gss_pkg::cfg_t regs
);
	import gss_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.node_low <= '0;
			regs_q.node_high <= '1;
			regs_q.sample_total <= '0;
			regs_q.empty_total <= '0;
			regs_q.node_size <= PROP_W'(1) << FRAC_W;
			regs_q.least_samples <= SAMPLE_W'(1);
			regs_q.least_size <= '0;
			regs_q.least_share <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NODE_LOW: begin
					regs_q.node_low <= cfg_data[COORD_W-1:0];
				end
				REG_NODE_HIGH: begin
					regs_q.node_high <= cfg_data[COORD_W-1:0];
				end
				REG_SAMPLE_TOTAL: begin
					regs_q.sample_total <= cfg_data[SAMPLE_W-1:0];
				end
				REG_EMPTY_TOTAL: begin
					regs_q.empty_total <= cfg_data[SAMPLE_W-1:0];
				end
				REG_NODE_SIZE: begin
					regs_q.node_size <= cfg_data[PROP_W-1:0];
				end
				REG_LEAST_SAMPLES: begin
					regs_q.least_samples <= cfg_data[SAMPLE_W-1:0];
				end
				REG_LEAST_SIZE: begin
					regs_q.least_size <= cfg_data[PROP_W-1:0];
				end
				REG_LEAST_SHARE: begin
					regs_q.least_share <= cfg_data[PROP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule
`default_nettype wire

### sv/gini_split_scan.sv
// Top level of the Gini split scan: sequencer, shared multiplier and result register.
`default_nettype none
// Scores candidate split points of one feature and keeps the best Gini gain.
// Each word on the item channel is one candidate; the word marked last yields
// one word on the result channel and clears the running best and hit counters.
// One candidate at a time is processed: item_stall stays high from acceptance
// until the candidate is finished. A node of zero length skips the arithmetic
// and a forbidden candidate ends after the limit check. An allowed candidate
// runs through the single shared divider, which produces one quotient bit per
// cycle over five divisions (two side shares of 17 bits, two side impurities of
// 38 bits and the final score of 17 bits), with the products between them on
// the shared 38 x 21 multiplier. A result waiting on a stalled result channel
// does not block the next candidate until that candidate is the last one of
// its scan.
module gini_split_scan (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input gss_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output gss_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PL,
		ST_PR,
		ST_MUL_EL,
		ST_MUL_ER,
		ST_MUL_VL,
		ST_MUL_VR,
		ST_CHECK,
		ST_MUL_TL,
		ST_TL,
		ST_MUL_TR,
		ST_TR,
		ST_SCORE,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_PL,
		OP_PR,
		OP_TL,
		OP_TR,
		OP_SCORE
	} op_t;

	cfg_t cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q;
	op_t op_q;
	logic div_go_q;
	logic result_valid_q;
	result_t result_q;
	logic [PROP_W-1:0] top_gain_q;
	logic [COORD_W-1:0] top_split_q;
	logic found_q;
	logic [COUNT_W-1:0] sample_hits_q;
	logic [COUNT_W-1:0] size_hits_q;
	logic [COUNT_W-1:0] share_hits_q;

	logic [COORD_W-1:0] split_q;
	logic [SAMPLE_W-1:0] nl_q;
	logic [SAMPLE_W-1:0] nr_q;
	logic last_q;
	logic [PROP_W-1:0] pl_q;
	logic [PROP_W-1:0] pr_q;
	logic [EMPTY_W-1:0] el_q;
	logic [EMPTY_W-1:0] er_q;
	logic [TOT_W-1:0] tot_l_q;
	logic [TOT_W-1:0] tot_r_q;
	logic [SUM_W-1:0] tot_sum_q;
	logic vol_l_hit_q;
	logic [QUO_W-1:0] tl_q;
	logic [QUO_W-1:0] tr_q;
	logic [MUL_W-1:0] mul_q;

	logic node_ok;
	logic [COORD_W-1:0] node_len;
	logic [COORD_W-1:0] split_clamp;
	logic [SAMPLE_W-1:0] right_count;
	logic mul_en;
	logic [EMPTY_W-1:0] mul_a;
	logic [SAMPLE_W-1:0] mul_b;
	logic [TOT_W-1:0] sample_lim;
	logic [MUL_W-1:0] size_lim;
	logic sample_hit;
	logic size_hit;
	logic share_hit;
	logic allowed;
	logic [PROP_W-1:0] half;
	logic [PROP_W-1:0] score;
	logic [PROP_W-1:0] gain;
	logic result_free;

	gss_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.regs(cfg)
	);

	gss_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign node_ok = (cfg.node_high > cfg.node_low);
	assign node_len = cfg.node_high - cfg.node_low;
	assign split_clamp = (item.split_value < cfg.node_low) ? cfg.node_low :
		(item.split_value > cfg.node_high) ? cfg.node_high : item.split_value;
	assign right_count = (cfg.sample_total >= item.left_count) ?
		cfg.sample_total - item.left_count : '0;

	// Divider operands follow the operation that the sequencer launched.
	always_comb begin
		div_req.go = div_go_q;
		div_req.qbits = QB_W'(PROP_W);
		div_req.num = '0;
		div_req.den = DIV_W'(node_len);
		case (op_q)
			OP_PL: begin
				div_req.num = NUM_W'(split_q - cfg.node_low) << FRAC_W;
			end
			OP_PR: begin
				div_req.num = NUM_W'(cfg.node_high - split_q) << FRAC_W;
			end
			OP_TL: begin
				div_req.qbits = QB_W'(QUO_W);
				div_req.num = NUM_W'(mul_q) << FRAC_W;
				div_req.den = DIV_W'(tot_l_q);
			end
			OP_TR: begin
				div_req.qbits = QB_W'(QUO_W);
				div_req.num = NUM_W'(mul_q) << FRAC_W;
				div_req.den = DIV_W'(tot_r_q);
			end
			OP_SCORE: begin
				div_req.num = NUM_W'({1'b0, tl_q} + {1'b0, tr_q}) << (FRAC_W + 1);
				div_req.den = tot_sum_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_EL: begin
				mul_a = EMPTY_W'(cfg.empty_total);
				mul_b = SAMPLE_W'(pl_q);
			end
			ST_MUL_ER: begin
				mul_a = EMPTY_W'(cfg.empty_total);
				mul_b = SAMPLE_W'(pr_q);
			end
			ST_MUL_VL: begin
				mul_a = EMPTY_W'(cfg.node_size);
				mul_b = SAMPLE_W'(pl_q);
			end
			ST_MUL_VR: begin
				mul_a = EMPTY_W'(cfg.node_size);
				mul_b = SAMPLE_W'(pr_q);
			end
			ST_MUL_TL: begin
				mul_a = el_q;
				mul_b = nl_q;
			end
			ST_MUL_TR: begin
				mul_a = er_q;
				mul_b = nr_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// In the check state the product register holds the right-side volume.
	assign sample_lim = TOT_W'(cfg.least_samples) << FRAC_W;
	assign size_lim = MUL_W'(cfg.least_size) << FRAC_W;
	assign sample_hit = (tot_l_q < sample_lim) || (tot_r_q < sample_lim);
	assign size_hit = vol_l_hit_q || (mul_q < size_lim);
	assign share_hit = (pl_q < cfg.least_share) || (pr_q < cfg.least_share);
	assign allowed = !sample_hit && !size_hit && !share_hit &&
		(tot_l_q != '0) && (tot_r_q != '0);

	assign half = PROP_W'(1) << (FRAC_W - 1);
	assign score = div_rsp.quo[PROP_W-1:0];
	assign gain = (score >= half) ? '0 : half - score;

	assign result_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_PL;
			div_go_q <= 1'b0;
			result_valid_q <= 1'b0;
			top_gain_q <= '0;
			top_split_q <= '0;
			found_q <= 1'b0;
			sample_hits_q <= '0;
			size_hits_q <= '0;
			share_hits_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (node_ok) begin
							state_q <= ST_PL;
							op_q <= OP_PL;
							div_go_q <= 1'b1;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_PL: begin
					if (div_rsp.done) begin
						state_q <= ST_PR;
						op_q <= OP_PR;
						div_go_q <= 1'b1;
					end
				end
				ST_PR: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL_EL;
					end
				end
				ST_MUL_EL: begin
					state_q <= ST_MUL_ER;
				end
				ST_MUL_ER: begin
					state_q <= ST_MUL_VL;
				end
				ST_MUL_VL: begin
					state_q <= ST_MUL_VR;
				end
				ST_MUL_VR: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sample_hit && sample_hits_q != '1) begin
						sample_hits_q <= sample_hits_q + 1'b1;
					end
					if (size_hit && size_hits_q != '1) begin
						size_hits_q <= size_hits_q + 1'b1;
					end
					if (share_hit && share_hits_q != '1) begin
						share_hits_q <= share_hits_q + 1'b1;
					end
					state_q <= allowed ? ST_MUL_TL : ST_FINISH;
				end
				ST_MUL_TL: begin
					state_q <= ST_TL;
					op_q <= OP_TL;
					div_go_q <= 1'b1;
				end
				ST_TL: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL_TR;
					end
				end
				ST_MUL_TR: begin
					state_q <= ST_TR;
					op_q <= OP_TR;
					div_go_q <= 1'b1;
				end
				ST_TR: begin
					if (div_rsp.done) begin
						state_q <= ST_SCORE;
						op_q <= OP_SCORE;
						div_go_q <= 1'b1;
					end
				end
				ST_SCORE: begin
					if (div_rsp.done) begin
						if (gain > top_gain_q) begin
							top_gain_q <= gain;
							top_split_q <= split_q;
							found_q <= 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (result_free) begin
						result_valid_q <= 1'b1;
						top_gain_q <= '0;
						top_split_q <= '0;
						found_q <= 1'b0;
						sample_hits_q <= '0;
						size_hits_q <= '0;
						share_hits_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			split_q <= split_clamp;
			nl_q <= item.left_count;
			nr_q <= right_count;
			last_q <= item.last;
		end
		if (mul_en) begin
			mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		end
		if (state_q == ST_PL && div_rsp.done) begin
			pl_q <= div_rsp.quo[PROP_W-1:0];
		end
		if (state_q == ST_PR && div_rsp.done) begin
			pr_q <= div_rsp.quo[PROP_W-1:0];
		end
		if (state_q == ST_MUL_ER) begin
			el_q <= mul_q[EMPTY_W-1:0];
		end
		if (state_q == ST_MUL_VL) begin
			er_q <= mul_q[EMPTY_W-1:0];
			tot_l_q <= TOT_W'(el_q) + (TOT_W'(nl_q) << FRAC_W);
		end
		if (state_q == ST_MUL_VR) begin
			vol_l_hit_q <= (mul_q < size_lim);
			tot_r_q <= TOT_W'(er_q) + (TOT_W'(nr_q) << FRAC_W);
		end
		if (state_q == ST_CHECK) begin
			tot_sum_q <= SUM_W'(tot_l_q) + SUM_W'(tot_r_q);
		end
		if (state_q == ST_TL && div_rsp.done) begin
			tl_q <= div_rsp.quo;
		end
		if (state_q == ST_TR && div_rsp.done) begin
			tr_q <= div_rsp.quo;
		end
		if (state_q == ST_FINISH && last_q && result_free) begin
			result_q.top_gain <= top_gain_q[FRAC_W-1:0];
			result_q.top_split <= top_split_q;
			result_q.found <= found_q;
			result_q.sample_hits <= sample_hits_q;
			result_q.size_hits <= size_hits_q;
			result_q.share_hits <= share_hits_q;
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
`default_nettype wire

### sv/gss_chk.sv
// Port-level checks of the Gini split scan, bound to its top level.
`default_nettype none
module gss_chk (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input gss_pkg::result_t result
);

	// Only one candidate is in flight, so an accepted word closes the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item channel open right after an accepted word");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed or dropped");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.top_gain == '0 && result.top_split == '0)
		else $error("result without a found split carries a gain or split");

	a_found_gains: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.top_gain != '0)
		else $error("found split reports zero gain");

endmodule

bind gini_split_scan gss_chk u_gss_chk (.*);
`default_nettype wire

### tb/gini_split_scan_tb.sv
// Self-checking testbench for the Gini split scan block with a scoreboard class.
module gini_split_scan_tb;
	import gss_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 3000;
	localparam int ITEMS_PER_PHASE = 180;
	localparam logic [63:0] HALF_GAIN = 64'd1 << (FRAC_W - 1);
	localparam int COUNT_MAX = 1048576;
	localparam int UNIT = 65536;

	// Keeps a copy of the registers and of the running best, and the queue of
	// summary words that the last candidate of each scan should produce.
	class split_scoreboard;
		cfg_t regs;
		logic [PROP_W-1:0] top_gain_q;
		logic [COORD_W-1:0] top_split_q;
		logic found_q;
		logic [COUNT_W-1:0] sample_hits_q, size_hits_q, share_hits_q;
		result_t summaries[$];
		int errors;

		function new();
			regs = '0;
			regs.node_high = '1;
			regs.node_size = PROP_W'(UNIT);
			regs.least_samples = SAMPLE_W'(1);
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			top_gain_q = '0;
			top_split_q = '0;
			found_q = 1'b0;
			sample_hits_q = '0;
			size_hits_q = '0;
			share_hits_q = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NODE_LOW: regs.node_low = data[COORD_W-1:0];
				REG_NODE_HIGH: regs.node_high = data[COORD_W-1:0];
				REG_SAMPLE_TOTAL: regs.sample_total = data;
				REG_EMPTY_TOTAL: regs.empty_total = data;
				REG_NODE_SIZE: regs.node_size = data[PROP_W-1:0];
				REG_LEAST_SAMPLES: regs.least_samples = data;
				REG_LEAST_SIZE: regs.least_size = data[PROP_W-1:0];
				REG_LEAST_SHARE: regs.least_share = data[PROP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		// Floor of a * b / d on a 128-bit product.
		function logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b, logic [63:0] d);
			logic [127:0] p;
			p = {64'd0, a};
			p = p * {64'd0, b};
			p = p / {64'd0, d};
			return p[63:0];
		endfunction

		function void note_item(item_t it);
			logic [63:0] s, nl, nr, lo, hi, len, pl, pr, el, er, lim, least_vol;
			logic [63:0] st, et, ns, tot_l, tot_r, tl, tr, score, gain;
			bit r_samp, r_vol, r_len;
			result_t want;
			s = 64'(it.split_value);
			nl = 64'(it.left_count);
			lo = 64'(regs.node_low);
			hi = 64'(regs.node_high);
			st = 64'(regs.sample_total);
			et = 64'(regs.empty_total);
			ns = 64'(regs.node_size);
			// A node of zero length scores nothing and leaves the counters alone.
			if (hi > lo) begin
				len = hi - lo;
				if (s < lo) s = lo;
				if (s > hi) s = hi;
				pl = ((s - lo) << FRAC_W) / len;
				pr = ((hi - s) << FRAC_W) / len;
				nr = (st >= nl) ? st - nl : 64'd0;
				el = et * pl;
				er = et * pr;
				lim = 64'(regs.least_samples) << FRAC_W;
				least_vol = 64'(regs.least_size) << FRAC_W;
				r_samp = (el + (nl << FRAC_W) < lim) || (er + (nr << FRAC_W) < lim);
				r_vol = (ns * pl < least_vol) || (ns * pr < least_vol);
				r_len = (pl < 64'(regs.least_share)) || (pr < 64'(regs.least_share));
				if (r_samp) sample_hits_q = sat_inc(sample_hits_q);
				if (r_vol) size_hits_q = sat_inc(size_hits_q);
				if (r_len) share_hits_q = sat_inc(share_hits_q);
				if (!r_samp && !r_vol && !r_len) begin
					tot_l = el + (nl << FRAC_W);
					tot_r = er + (nr << FRAC_W);
					if (tot_l != 0 && tot_r != 0) begin
						tl = scaled_quotient(el, nl << FRAC_W, tot_l);
						tr = scaled_quotient(er, nr << FRAC_W, tot_r);
						score = scaled_quotient(64'd2 * (tl + tr), 64'd1 << FRAC_W,
							tot_l + tot_r);
						gain = (score >= HALF_GAIN) ? 64'd0 : HALF_GAIN - score;
						if (gain > 64'(top_gain_q)) begin
							top_gain_q = gain[PROP_W-1:0];
							top_split_q = s[COORD_W-1:0];
							found_q = 1'b1;
						end
					end
				end
			end
			if (it.last) begin
				want.top_gain = top_gain_q[FRAC_W-1:0];
				want.top_split = top_split_q;
				want.found = found_q;
				want.sample_hits = sample_hits_q;
				want.size_hits = size_hits_q;
				want.share_hits = share_hits_q;
				summaries.push_back(want);
				clear_scan();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (summaries.size() == 0) begin
				$error("result word with no summary pending");
				errors++;
			end else begin
				want = summaries.pop_front();
				compare_field("top_gain", 32'(want.top_gain), 32'(got.top_gain));
				compare_field("top_split", 32'(want.top_split), 32'(got.top_split));
				compare_field("found", 32'(want.found), 32'(got.found));
				compare_field("sample_hits", 32'(want.sample_hits), 32'(got.sample_hits));
				compare_field("size_hits", 32'(want.size_hits), 32'(got.size_hits));
				compare_field("share_hits", 32'(want.share_hits), 32'(got.share_hits));
			end
		endfunction

		function bit drained();
			return summaries.size() == 0;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	split_scoreboard sb = new();
	int tx_pct = 0;
	int rx_pct = 0;
	bit rx_hold = 1'b0;
	int hold_count = 0;

	gini_split_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: checks accepted words and owns the stall, including the long hold.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
		if (rx_hold && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			result_stall <= 1'b1;
		end else begin
			if (!rx_hold) hold_count <= 0;
			result_stall <= ($urandom_range(0, 99) < rx_pct);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_node(int lo, int hi, int st, int et, int ns, int ls, int lz, int lh);
		write_reg(REG_NODE_LOW, CFG_DATA_W'(lo));
		write_reg(REG_NODE_HIGH, CFG_DATA_W'(hi));
		write_reg(REG_SAMPLE_TOTAL, CFG_DATA_W'(st));
		write_reg(REG_EMPTY_TOTAL, CFG_DATA_W'(et));
		write_reg(REG_NODE_SIZE, CFG_DATA_W'(ns));
		write_reg(REG_LEAST_SAMPLES, CFG_DATA_W'(ls));
		write_reg(REG_LEAST_SIZE, CFG_DATA_W'(lz));
		write_reg(REG_LEAST_SHARE, CFG_DATA_W'(lh));
	endtask

	task automatic send_item(int split, int left, bit is_last);
		while ($urandom_range(0, 99) < tx_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item.split_value <= COORD_W'(split);
		item.left_count <= SAMPLE_W'(left);
		item.last <= is_last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_item('{split_value: COORD_W'(split), left_count: SAMPLE_W'(left),
			last: is_last});
	endtask

	// Waits for every summary, then gives the block time to finish its candidate.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (!sb.drained()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_node();
		int lo, hi, a, b;
		case ($urandom_range(0, 9))
			0: begin
				lo = $urandom_range(0, 65535);
				hi = $urandom_range(0, lo);
			end
			1: begin
				lo = 0;
				hi = 65535;
			end
			default: begin
				a = $urandom_range(0, 65535);
				b = $urandom_range(0, 65535);
				if (a == b) b = a ^ 1;
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
		endcase
		a = $urandom_range(0, 99);
		write_node(lo, hi,
			(a < 10) ? COUNT_MAX : (a < 20) ? 0 : (a < 50) ? $urandom_range(0, COUNT_MAX)
				: $urandom_range(1, 2000),
			($urandom_range(0, 9) == 0) ? COUNT_MAX : ($urandom_range(0, 2) == 0) ? 0
				: ($urandom_range(0, 1) == 0) ? $urandom_range(0, COUNT_MAX)
				: $urandom_range(0, 2000),
			($urandom_range(0, 9) == 0) ? UNIT : ($urandom_range(0, 15) == 0) ? 0
				: $urandom_range(0, UNIT),
			($urandom_range(0, 19) == 0) ? COUNT_MAX : ($urandom_range(0, 9) == 0)
				? $urandom_range(0, COUNT_MAX) : $urandom_range(0, 20),
			($urandom_range(0, 19) == 0) ? UNIT : ($urandom_range(0, 1) == 0) ? 0
				: $urandom_range(0, 2000),
			($urandom_range(0, 19) == 0) ? UNIT : ($urandom_range(0, 1) == 0) ? 0
				: $urandom_range(0, 8000));
	endtask

	// Most splits fall inside the node; some sit on or beyond a bound.
	task automatic random_candidate(bit is_last);
		int lo, hi, st, r, split, left;
		lo = int'(sb.regs.node_low);
		hi = int'(sb.regs.node_high);
		st = int'(sb.regs.sample_total);
		r = $urandom_range(0, 99);
		if (r < 8 || hi <= lo) split = $urandom_range(0, 65535);
		else if (r < 12) split = lo;
		else if (r < 16) split = hi;
		else split = $urandom_range(lo, hi);
		r = $urandom_range(0, 99);
		if (r < 5) left = COUNT_MAX;
		else if (r < 10) left = $urandom_range(0, COUNT_MAX);
		else if (r < 15) left = st;
		else left = $urandom_range(0, st);
		send_item(split, left, is_last);
	endtask

	initial begin
		int sent, scans, len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the sample total is zero, so the right side is always short of samples.
		send_item(0, 0, 1'b0);
		send_item(65535, COUNT_MAX, 1'b0);
		send_item(32768, 0, 1'b1);
		drain();

		// Splits clamped at both bounds and a left count above the total.
		write_node(1000, 50000, 1000, 500, 40000, 5, 0, 0);
		send_item(0, 300, 1'b0);
		send_item(65535, 1000, 1'b0);
		send_item(25000, 500, 1'b0);
		send_item(12000, 200, 1'b0);
		send_item(30000, COUNT_MAX, 1'b0);
		send_item(40000, 800, 1'b1);
		drain();

		// Zero-length node, then bounds inverted.
		write_node(3000, 3000, 100, 100, 30000, 1, 0, 0);
		send_item(3000, 5, 1'b0);
		send_item(100, 0, 1'b1);
		drain();
		write_reg(REG_NODE_HIGH, CFG_DATA_W'(2000));
		send_item(2500, 1, 1'b1);
		drain();

		// A side with no samples at all can never win.
		write_node(0, 65535, 10, 0, UNIT, 0, 0, 0);
		send_item(0, 0, 1'b0);
		send_item(65535, 10, 1'b1);
		drain();

		// Every limit at its top value.
		write_node(0, 65535, COUNT_MAX, COUNT_MAX, UNIT, COUNT_MAX, UNIT, UNIT);
		send_item(32768, 524288, 1'b0);
		send_item(0, COUNT_MAX, 1'b0);
		send_item(65535, 0, 1'b1);
		drain();

		write_node(100, 65000, 5000, 20000, 30000, 50, 3000, 6000);
		send_item(500, 10, 1'b0);
		send_item(32000, 2500, 1'b0);
		send_item(64900, 4990, 1'b0);
		send_item(20000, 1500, 1'b1);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin tx_pct = 0; rx_pct <= 0; end
				1: begin tx_pct = 74; rx_pct <= 0; end
				2: begin tx_pct = 0; rx_pct <= 74; end
				3: begin tx_pct = 30; rx_pct <= 30; end
				default: begin tx_pct = 0; rx_pct <= 0; rx_hold <= 1'b1; end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				random_node();
				scans = $urandom_range(2, 6);
				repeat (scans) begin
					len = $urandom_range(1, 10);
					for (int k = 0; k < len; k++) random_candidate(k == len - 1);
					sent += len;
				end
				drain();
			end
			rx_hold <= 1'b0;
			@(posedge clk);
		end

		drain();
		if (sb.errors == 0 && sb.drained()) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("tb: failure");
		$finish;
	end

endmodule
